// ===== sv/altitude_velocity_kalman_filter_macros.svh =====
// assertion macros for the altitude/velocity kalman filter
// no dependencies; included by the top level
`ifndef ALTITUDE_VELOCITY_KALMAN_FILTER_MACROS_SVH
`define ALTITUDE_VELOCITY_KALMAN_FILTER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define AVKF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("avkf assertion failed");

// consequent checked in the cycle after the antecedent
`define AVKF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("avkf assertion failed");

`endif

// ===== sv/avkf_pkg.sv =====
// shared constants of the altitude/velocity kalman filter
// no dependencies
package avkf_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 32;
   localparam int StepTimeWidth = 17;
   localparam int FieldWidth    = 32;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_STEP_TIME    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_ALT_NOISE    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_VEL_NOISE    = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_MEAS_NOISE   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_INIT_ALT_VAR = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_INIT_VEL_VAR = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_GROUND_LEVEL = 3'd6;

   // register reset values
   localparam logic [StepTimeWidth-1:0] RST_STEP_TIME    = 17'd655;
   localparam logic [CsrDataWidth-1:0]  RST_ALT_NOISE    = 32'd6554;
   localparam logic [CsrDataWidth-1:0]  RST_VEL_NOISE    = 32'd65536;
   localparam logic [CsrDataWidth-1:0]  RST_MEAS_NOISE   = 32'd131072;
   localparam logic [CsrDataWidth-1:0]  RST_INIT_ALT_VAR = 32'd655360;
   localparam logic [CsrDataWidth-1:0]  RST_INIT_VEL_VAR = 32'd655360;
   localparam logic [CsrDataWidth-1:0]  RST_GROUND_LEVEL = 32'd0;

   // sequencer steps of the arithmetic program
   localparam logic [3:0] ST_MUL_DT_V     = 4'd0;
   localparam logic [3:0] ST_XP           = 4'd1;
   localparam logic [3:0] ST_PAA_AV       = 4'd2;
   localparam logic [3:0] ST_PAA_VA       = 4'd3;
   localparam logic [3:0] ST_DTDT         = 4'd4;
   localparam logic [3:0] ST_MUL_DTDT_VV  = 4'd5;
   localparam logic [3:0] ST_PAA_VV       = 4'd6;
   localparam logic [3:0] ST_PREDICT_DONE = 4'd7;
   localparam logic [3:0] ST_INNOV_VAR    = 4'd8;
   localparam logic [3:0] ST_ONE_MINUS_K  = 4'd9;
   localparam logic [3:0] ST_ALT_UPD      = 4'd10;
   localparam logic [3:0] ST_VEL_UPD      = 4'd11;
   localparam logic [3:0] ST_COV_AA       = 4'd12;
   localparam logic [3:0] ST_COV_AV       = 4'd13;
   localparam logic [3:0] ST_COV_VA       = 4'd14;
   localparam logic [3:0] ST_COV_VV       = 4'd15;

endpackage

// ===== sv/altitude_velocity_kalman_filter.sv =====
// two-state constant-velocity kalman filter over one shared multiplier and
// a bit-serial divider; depends on avkf_pkg and the assertion macro header
//
//  channel | direction | handshake                  | beat
//  req     | in        | req_valid / req_ready      | one altitude sample
//  rsp     | out       | rsp_valid / rsp_ready      | estimates and flags
//  csr     | in        | csr_write_enable (no wait) | one register write
//
// initializing beat: loads the initial state and goes straight to rsp_valid;
// prediction only: the prediction steps; with measurement: also the serial
// divider, which forms both gains one quotient bit a cycle, and the update steps
// req_ready is high only while idle; one beat is in flight at a time
// reset (synchronous) restores register defaults and the uninitialized filter
`include "altitude_velocity_kalman_filter_macros.svh"

module altitude_velocity_kalman_filter
   import avkf_pkg::*;
#(
   parameter int DATA_WIDTH    = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [FieldWidth-1:0] req_measured_altitude,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [FieldWidth-1:0] rsp_altitude_estimate,
   output logic signed [FieldWidth-1:0] rsp_velocity_estimate,
   output logic                     rsp_measurement_applied,
   output logic                     rsp_was_initializing,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data
);

   localparam int D  = DATA_WIDTH;
   localparam int F  = FRACTION_BITS;
   localparam int QW = D + F;
   localparam int CW = $clog2(QW + 1);
   localparam int PW = 2 * D;
   localparam logic [63:0] DMAX64 = (64'd1 << (D - 1)) - 64'd1;

   typedef logic signed [D-1:0] fix_type;
   typedef enum logic [1:0] {IDLE, CALC, DIVIDE, RESPOND} state_type;

   localparam fix_type DMAX    = fix_type'(DMAX64);
   localparam fix_type DMIN    = ~DMAX;
   localparam fix_type ONE_FIX = fix_type'(64'd1 << F);

   // saturating arithmetic helpers
   function automatic fix_type sat_wide(input logic signed [D:0] v);
      if (v[D] != v[D-1]) return v[D] ? DMIN : DMAX;
      return v[D-1:0];
   endfunction

   function automatic fix_type sat_add(input fix_type a, input fix_type b);
      return sat_wide({a[D-1], a} + {b[D-1], b});
   endfunction

   function automatic fix_type sat_sub(input fix_type a, input fix_type b);
      return sat_wide({a[D-1], a} - {b[D-1], b});
   endfunction

   function automatic fix_type reg_u(input logic [CsrDataWidth-1:0] r);
      logic [63:0] w;
      w = 64'(r);
      if (w > DMAX64) return DMAX;
      return fix_type'(w);
   endfunction

   function automatic fix_type sext32(input logic [FieldWidth-1:0] r);
      logic signed [63:0] w;
      w = 64'(signed'(r));
      if (w > signed'(DMAX64)) return DMAX;
      if (w < -signed'(DMAX64) - 64'sd1) return DMIN;
      return fix_type'(w);
   endfunction

   function automatic logic [FieldWidth-1:0] out32(input fix_type v);
      logic signed [63:0] w;
      w = 64'(v);
      if (w > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (w < -64'sh8000_0000) return 32'h8000_0000;
      return w[FieldWidth-1:0];
   endfunction

   function automatic logic [D-1:0] mag(input fix_type v);
      logic [D-1:0] u;
      u = v;
      return u[D-1] ? (~u + 1'b1) : u;
   endfunction

   state_type state_ff;
   logic [3:0] step_ff;
   logic       filter_ready_ff;

   // configuration registers
   logic [StepTimeWidth-1:0] dt_ff;
   logic [CsrDataWidth-1:0]  alt_noise_ff, vel_noise_ff, meas_noise_ff;
   logic [CsrDataWidth-1:0]  init_alt_var_ff, init_vel_var_ff, ground_ff;

   // filter state and working values
   fix_type alt_ff, vel_ff, paa_st_ff, pav_st_ff, pva_st_ff, pvv_st_ff;
   fix_type z_ff, xp_ff, paa_ff, pav_ff, pva_ff, pvv_ff, s_ff, y_ff;
   fix_type k0_ff, k1_ff, t_ff;
   logic    applied_ff, init_ff;

   // shared multiplier
   fix_type        mul_a, mul_b, mul_res, dt_fix;
   logic [PW-1:0]  prod_ff;
   logic           pneg_ff;
   logic [PW:0]    rnd_sum, rnd_shift, rnd_lim, rnd_mag;

   // serial divider
   logic [D:0]     rem_ff;
   logic [QW-1:0]  dvd_ff, quo_ff;
   logic [D-1:0]   md_ff;
   logic           dneg_ff, second_div_ff;
   logic [CW-1:0]  div_cnt_ff;
   logic [D:0]     rem_try;
   logic           rem_ge;
   logic [QW-1:0]  quo_next, quo_lim, quo_mag;
   fix_type        div_res;
   fix_type        s_calc;

   assign dt_fix = reg_u(CsrDataWidth'(dt_ff));

   // innovation variance from the predicted altitude variance
   assign s_calc = sat_add(paa_ff, reg_u(meas_noise_ff));

   // operand select for each program step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         ST_MUL_DT_V:    begin mul_a = dt_fix; mul_b = vel_ff;    end
         ST_XP:          begin mul_a = dt_fix; mul_b = pav_st_ff; end
         ST_PAA_AV:      begin mul_a = dt_fix; mul_b = pva_st_ff; end
         ST_PAA_VA:      begin mul_a = dt_fix; mul_b = dt_fix;    end
         ST_MUL_DTDT_VV: begin mul_a = t_ff;   mul_b = pvv_st_ff; end
         ST_PAA_VV:      begin mul_a = dt_fix; mul_b = pvv_st_ff; end
         ST_ONE_MINUS_K: begin mul_a = k0_ff;  mul_b = y_ff;      end
         ST_ALT_UPD:     begin mul_a = k1_ff;  mul_b = y_ff;      end
         ST_VEL_UPD:     begin mul_a = t_ff;   mul_b = paa_ff;    end
         ST_COV_AA:      begin mul_a = t_ff;   mul_b = pav_ff;    end
         ST_COV_AV:      begin mul_a = k1_ff;  mul_b = paa_ff;    end
         ST_COV_VA:      begin mul_a = k1_ff;  mul_b = pav_ff;    end
         default:        begin mul_a = '0;     mul_b = '0;        end
      endcase
   end

   // round to nearest on magnitude, ties away, then sign and saturate
   always_comb begin
      rnd_sum   = {1'b0, prod_ff} + ((PW + 1)'(1) << (F - 1));
      rnd_shift = rnd_sum >> F;
      rnd_lim   = pneg_ff ? ((PW + 1)'(1) << (D - 1)) : (PW + 1)'(DMAX64);
      rnd_mag   = (rnd_shift > rnd_lim) ? rnd_lim : rnd_shift;
      mul_res   = pneg_ff ? fix_type'(~rnd_mag[D-1:0] + 1'b1) : fix_type'(rnd_mag[D-1:0]);
   end

   // one restoring step and the saturated quotient
   always_comb begin
      rem_try  = {rem_ff[D-1:0], dvd_ff[QW-1]};
      rem_ge   = rem_try >= {1'b0, md_ff};
      quo_next = {quo_ff[QW-2:0], rem_ge};
      quo_lim  = dneg_ff ? (QW'(1) << (D - 1)) : QW'(DMAX64);
      quo_mag  = (quo_ff > quo_lim) ? quo_lim : quo_ff;
      if (md_ff == '0) div_res = '0;
      else if (dneg_ff) div_res = fix_type'(~quo_mag[D-1:0] + 1'b1);
      else div_res = fix_type'(quo_mag[D-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= IDLE;
         step_ff         <= ST_MUL_DT_V;
         filter_ready_ff <= 1'b0;
         dt_ff           <= RST_STEP_TIME;
         alt_noise_ff    <= RST_ALT_NOISE;
         vel_noise_ff    <= RST_VEL_NOISE;
         meas_noise_ff   <= RST_MEAS_NOISE;
         init_alt_var_ff <= RST_INIT_ALT_VAR;
         init_vel_var_ff <= RST_INIT_VEL_VAR;
         ground_ff       <= RST_GROUND_LEVEL;
         alt_ff          <= '0;
         vel_ff          <= '0;
         paa_st_ff       <= '0;
         pav_st_ff       <= '0;
         pva_st_ff       <= '0;
         pvv_st_ff       <= '0;
         applied_ff      <= 1'b0;
         init_ff         <= 1'b0;
         second_div_ff   <= 1'b0;
         div_cnt_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_STEP_TIME:    dt_ff           <= csr_write_data[StepTimeWidth-1:0];
               CSR_ALT_NOISE:    alt_noise_ff    <= csr_write_data;
               CSR_VEL_NOISE:    vel_noise_ff    <= csr_write_data;
               CSR_MEAS_NOISE:   meas_noise_ff   <= csr_write_data;
               CSR_INIT_ALT_VAR: init_alt_var_ff <= csr_write_data;
               CSR_INIT_VEL_VAR: init_vel_var_ff <= csr_write_data;
               CSR_GROUND_LEVEL: ground_ff       <= csr_write_data;
               default: ;
            endcase
         end

         // multiplier register runs every cycle, its result is consumed in the following step
         prod_ff <= PW'(mag(mul_a)) * PW'(mag(mul_b));
         pneg_ff <= mul_a[D-1] ^ mul_b[D-1];

         case (state_ff)
            IDLE: begin
               step_ff <= ST_MUL_DT_V;
               if (req_valid) begin
                  z_ff <= sext32(req_measured_altitude);
                  applied_ff <= 1'b0;
                  if (!filter_ready_ff) begin
                     // first beat only loads the initial state
                     alt_ff          <= sext32(ground_ff);
                     vel_ff          <= '0;
                     paa_st_ff       <= reg_u(init_alt_var_ff);
                     pav_st_ff       <= '0;
                     pva_st_ff       <= '0;
                     pvv_st_ff       <= reg_u(init_vel_var_ff);
                     filter_ready_ff <= 1'b1;
                     init_ff         <= 1'b1;
                     state_ff        <= RESPOND;
                  end else begin
                     init_ff  <= 1'b0;
                     state_ff <= CALC;
                  end
               end
            end
            CALC: begin
               step_ff <= step_ff + 4'd1;
               case (step_ff)
                  ST_XP:          xp_ff  <= sat_add(alt_ff, mul_res);
                  ST_PAA_AV:      paa_ff <= sat_add(paa_st_ff, mul_res);
                  ST_PAA_VA:      paa_ff <= sat_add(paa_ff, mul_res);
                  ST_DTDT:        t_ff   <= mul_res;
                  ST_PAA_VV:      paa_ff <= sat_add(paa_ff, mul_res);
                  ST_PREDICT_DONE: begin
                     paa_ff <= sat_add(paa_ff, reg_u(alt_noise_ff));
                     pav_ff <= sat_add(pav_st_ff, mul_res);
                     pva_ff <= sat_add(pva_st_ff, mul_res);
                     pvv_ff <= sat_add(pvv_st_ff, reg_u(vel_noise_ff));
                     y_ff   <= sat_sub(z_ff, xp_ff);
                     if (z_ff[D-1] || z_ff == '0) begin
                        // no measurement: commit the prediction
                        alt_ff    <= xp_ff;
                        paa_st_ff <= sat_add(paa_ff, reg_u(alt_noise_ff));
                        pav_st_ff <= sat_add(pav_st_ff, mul_res);
                        pva_st_ff <= sat_add(pva_st_ff, mul_res);
                        pvv_st_ff <= sat_add(pvv_st_ff, reg_u(vel_noise_ff));
                        state_ff  <= RESPOND;
                     end
                  end
                  ST_INNOV_VAR: begin
                     s_ff          <= s_calc;
                     md_ff         <= mag(s_calc);
                     dneg_ff       <= paa_ff[D-1] ^ s_calc[D-1];
                     dvd_ff        <= {mag(paa_ff), F'(0)};
                     rem_ff        <= '0;
                     quo_ff        <= '0;
                     div_cnt_ff    <= CW'(QW);
                     second_div_ff <= 1'b0;
                     state_ff      <= DIVIDE;
                  end
                  ST_ONE_MINUS_K: t_ff   <= sat_sub(ONE_FIX, k0_ff);
                  ST_ALT_UPD:     alt_ff <= sat_add(xp_ff, mul_res);
                  ST_VEL_UPD: begin
                     vel_ff <= sat_add(vel_ff, mul_res);
                     k1_ff  <= sat_sub('0, k1_ff);
                  end
                  ST_COV_AA:      paa_st_ff <= mul_res;
                  ST_COV_AV:      pav_st_ff <= mul_res;
                  ST_COV_VA:      pva_st_ff <= sat_add(mul_res, pva_ff);
                  ST_COV_VV: begin
                     pvv_st_ff  <= sat_add(mul_res, pvv_ff);
                     applied_ff <= 1'b1;
                     state_ff   <= RESPOND;
                  end
                  default: ;
               endcase
            end
            DIVIDE: begin
               if (div_cnt_ff != '0) begin
                  rem_ff     <= rem_ge ? (rem_try - {1'b0, md_ff}) : rem_try;
                  quo_ff     <= quo_next;
                  dvd_ff     <= {dvd_ff[QW-2:0], 1'b0};
                  div_cnt_ff <= div_cnt_ff - 1'b1;
               end else if (!second_div_ff) begin
                  // altitude gain done, start the velocity gain
                  k0_ff         <= div_res;
                  dneg_ff       <= pva_ff[D-1] ^ s_ff[D-1];
                  dvd_ff        <= {mag(pva_ff), F'(0)};
                  rem_ff        <= '0;
                  quo_ff        <= '0;
                  div_cnt_ff    <= CW'(QW);
                  second_div_ff <= 1'b1;
               end else begin
                  k1_ff    <= div_res;
                  step_ff  <= ST_ONE_MINUS_K;
                  state_ff <= CALC;
               end
            end
            RESPOND: begin
               if (rsp_ready) state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_ready               = (state_ff == IDLE);
   assign rsp_valid               = (state_ff == RESPOND);
   assign rsp_altitude_estimate   = out32(alt_ff);
   assign rsp_velocity_estimate   = out32(vel_ff);
   assign rsp_measurement_applied = applied_ff;
   assign rsp_was_initializing    = init_ff;

   // one beat in flight: never ready for a sample while a result is offered
   `AVKF_ASSERT_SAME(a_one_in_flight, clock, reset, rsp_valid, !req_ready)
   // an initializing beat never reports an applied measurement
   `AVKF_ASSERT_SAME(a_init_not_applied, clock, reset, rsp_valid && rsp_was_initializing, !rsp_measurement_applied)
   // after a result is taken the block is idle again
   `AVKF_ASSERT_NEXT(a_back_to_idle, clock, reset, rsp_valid && rsp_ready, req_ready && !rsp_valid)
   // a sample taken before initialization yields an initializing result
   `AVKF_ASSERT_NEXT(a_init_first, clock, reset, req_valid && req_ready && !filter_ready_ff, rsp_valid && rsp_was_initializing)

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the altitude/velocity kalman filter: a cycle-free
// predictor, a queued driver, a monitor and random stalls on both sides
// depends on avkf_pkg and the altitude_velocity_kalman_filter rtl
module tb_top;
   import avkf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;
   localparam longint UNIT = 64'sd65536;

   typedef struct {
      logic signed [FieldWidth-1:0] altitude;
      logic signed [FieldWidth-1:0] velocity;
      logic                         applied;
      logic                         initializing;
   } estimate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [FieldWidth-1:0] req_measured_altitude = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [FieldWidth-1:0] rsp_altitude_estimate;
   logic signed [FieldWidth-1:0] rsp_velocity_estimate;
   logic rsp_measurement_applied;
   logic rsp_was_initializing;
   logic csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_write_data = '0;

   altitude_velocity_kalman_filter u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_measured_altitude   (req_measured_altitude),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_altitude_estimate   (rsp_altitude_estimate),
      .rsp_velocity_estimate   (rsp_velocity_estimate),
      .rsp_measurement_applied (rsp_measurement_applied),
      .rsp_was_initializing    (rsp_was_initializing),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // filter predictor: own copy of registers and state
   // ---------------------------------------------------------------------
   longint csr_shadow [7];
   longint alt_est, vel_est, cov_aa, cov_av, cov_va, cov_vv;
   bit     filter_loaded;

   estimate_type expected_estimates[$];
   logic signed [FieldWidth-1:0] sample_queue[$];
   int mismatch_count = 0;

   function automatic longint clamp_q(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
   endfunction

   function automatic longint add_q(longint a, longint b);
      return clamp_q(a + b);
   endfunction

   // give a magnitude its sign, with the asymmetric two's complement limit
   function automatic longint apply_sign(longint unsigned m, bit neg);
      longint unsigned lim;
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      if (m > lim) m = lim;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   // product rounded to nearest on magnitude, ties away from zero
   function automatic longint mul_q(longint a, longint b);
      longint unsigned ma, mb, p;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      p = (ma * mb + 64'd32768) >> 16;
      return apply_sign(p, (a < 0) != (b < 0));
   endfunction

   // gain quotient truncated toward zero, zero when the divisor is zero
   function automatic longint div_q(longint n, longint d);
      longint unsigned mn, md;
      if (d == 0) return 0;
      mn = n < 0 ? -n : n;
      md = d < 0 ? -d : d;
      return apply_sign((mn << 16) / md, (n < 0) != (d < 0));
   endfunction

   // unsigned registers beyond the signed range saturate when used
   function automatic longint reg_value(int idx);
      return csr_shadow[idx] > QMAX ? QMAX : csr_shadow[idx];
   endfunction

   function automatic estimate_type filter_step(logic signed [FieldWidth-1:0] z_in);
      estimate_type r;
      longint z, dt, xp, vp, paa, pav, pva, pvv, y, s, k0, k1, omk, nk1;
      z = z_in;
      r.applied = 1'b0;
      r.initializing = 1'b0;
      if (!filter_loaded) begin
         alt_est = longint'($signed(csr_shadow[CSR_GROUND_LEVEL][31:0]));
         vel_est = 0;
         cov_aa = reg_value(CSR_INIT_ALT_VAR);
         cov_av = 0;
         cov_va = 0;
         cov_vv = reg_value(CSR_INIT_VEL_VAR);
         filter_loaded = 1'b1;
         r.initializing = 1'b1;
      end else begin
         dt = reg_value(CSR_STEP_TIME);
         xp = add_q(alt_est, mul_q(dt, vel_est));
         vp = vel_est;
         paa = add_q(cov_aa, mul_q(dt, cov_av));
         paa = add_q(paa, mul_q(dt, cov_va));
         paa = add_q(paa, mul_q(mul_q(dt, dt), cov_vv));
         paa = add_q(paa, reg_value(CSR_ALT_NOISE));
         pav = add_q(cov_av, mul_q(dt, cov_vv));
         pva = add_q(cov_va, mul_q(dt, cov_vv));
         pvv = add_q(cov_vv, reg_value(CSR_VEL_NOISE));
         if (z > 0) begin
            y = clamp_q(z - xp);
            s = add_q(paa, reg_value(CSR_MEAS_NOISE));
            k0 = div_q(paa, s);
            k1 = div_q(pva, s);
            omk = clamp_q(UNIT - k0);
            nk1 = clamp_q(-k1);
            alt_est = add_q(xp, mul_q(k0, y));
            vel_est = add_q(vp, mul_q(k1, y));
            cov_aa = mul_q(omk, paa);
            cov_av = mul_q(omk, pav);
            cov_va = add_q(mul_q(nk1, paa), pva);
            cov_vv = add_q(mul_q(nk1, pav), pvv);
            r.applied = 1'b1;
         end else begin
            alt_est = xp;
            vel_est = vp;
            cov_aa = paa;
            cov_av = pav;
            cov_va = pva;
            cov_vv = pvv;
         end
      end
      r.altitude = alt_est[31:0];
      r.velocity = vel_est[31:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // monitor: predicts on each request beat, checks each response beat
   // ---------------------------------------------------------------------
   bit sample_taken = 1'b0;

   always @(posedge clock) begin
      estimate_type want;
      sample_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            sample_taken = 1'b1;
            expected_estimates.push_back(filter_step(req_measured_altitude));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_estimates.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response beat with nothing expected", $realtime);
            end else begin
               want = expected_estimates.pop_front();
               if (rsp_altitude_estimate !== want.altitude ||
                   rsp_velocity_estimate !== want.velocity ||
                   rsp_measurement_applied !== want.applied ||
                   rsp_was_initializing !== want.initializing) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: exp alt %0d vel %0d app %0b init %0b, got %0d %0d %0b %0b",
                        $realtime, want.altitude, want.velocity, want.applied,
                        want.initializing, rsp_altitude_estimate, rsp_velocity_estimate,
                        rsp_measurement_applied, rsp_was_initializing);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // driver: bursts of samples with random gaps between them
   // ---------------------------------------------------------------------
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin
      logic next_valid;
      next_valid = req_valid;
      if (!reset && (!req_valid || sample_taken)) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (sample_queue.size() > 0) begin
            next_valid = 1'b1;
            req_measured_altitude <= sample_queue.pop_front();
            if (burst_left == 0) burst_left = $urandom_range(1, 24);
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 40)
                                                      : $urandom_range(0, 2);
         end
      end
      req_valid <= next_valid;
   end

   // ---------------------------------------------------------------------
   // receiver: stall pattern switches at random among four patterns of ready cycles
   // ---------------------------------------------------------------------
   bit hold_rsp = 1'b0;
   int stall_mode = 0;
   int mode_left = 0;
   int pattern_phase = 0;

   always @(negedge clock) begin
      logic next_ready;
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      pattern_phase++;
      case (stall_mode)
         0: next_ready = 1'b1;                                 // no stalls
         1: next_ready = ($urandom_range(0, 1) == 1);
         2: next_ready = (pattern_phase % 5) == 0;             // slow reader
         default: next_ready = $urandom_range(0, 7) != 0;
      endcase
      rsp_ready <= next_ready && !hold_rsp && !reset;
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   longint track_alt = 64'sd6553600;
   longint track_vel = 0;

   task automatic write_reg(logic [CsrIndexWidth-1:0] idx, longint unsigned value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[31:0];
      csr_shadow[idx] = (idx == CSR_STEP_TIME) ? (value & 64'h1FFFF) : (value & 64'hFFFFFFFF);
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // sender pause: nothing queued, nothing in flight, then the block's latency
   task automatic wait_idle();
      wait (sample_queue.size() == 0 && !req_valid && expected_estimates.size() == 0);
      repeat (120) @(posedge clock);
   endtask

   function automatic longint unsigned pick_noise();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 64'hFFFFFFFF;
         2: return $urandom();
         default: return $urandom_range(0, 1 << 20);
      endcase
   endfunction

   task automatic random_settings(bit extreme);
      write_reg(CSR_STEP_TIME, extreme ? ($urandom_range(0, 1) ? 1 : 65536)
                                        : $urandom_range(1, 65536));
      write_reg(CSR_ALT_NOISE, pick_noise());
      write_reg(CSR_VEL_NOISE, pick_noise());
      write_reg(CSR_MEAS_NOISE, pick_noise());
      write_reg(CSR_INIT_ALT_VAR, pick_noise());
      write_reg(CSR_INIT_VEL_VAR, pick_noise());
      write_reg(CSR_GROUND_LEVEL, $urandom());
      end_writes();
   endtask

   function automatic logic signed [FieldWidth-1:0] random_sample();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
         // plausible flight: positive altitude drifting with noise
         track_vel = track_vel + $signed($urandom_range(0, 8192)) - 4096;
         if (track_vel > 64'sd3276800 || track_vel < -64'sd3276800) track_vel = 0;
         track_alt = track_alt + track_vel / 100;
         if (track_alt < 64'sd65536 || track_alt > 64'sd1000000000) track_alt = 64'sd6553600;
         return 32'(track_alt + $signed($urandom_range(0, 131072)) - 65536);
      end
      if (pick < 14) return 32'(-$signed({1'b0, $urandom_range(0, 1000000)}));
      if (pick == 14) return 32'sd0;
      if (pick == 15) return ($urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000);
      return $urandom();
   endfunction

   initial begin
      csr_shadow = '{655, 6554, 65536, 131072, 655360, 655360, 0};
      filter_loaded = 1'b0;
      alt_est = 0; vel_est = 0;
      cov_aa = 0; cov_av = 0; cov_va = 0; cov_vv = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero covariance and zero measurement noise: innovation variance is zero
      write_reg(CSR_STEP_TIME, 65536);
      write_reg(CSR_ALT_NOISE, 0);
      write_reg(CSR_VEL_NOISE, 0);
      write_reg(CSR_MEAS_NOISE, 0);
      write_reg(CSR_INIT_ALT_VAR, 0);
      write_reg(CSR_INIT_VEL_VAR, 0);
      write_reg(CSR_GROUND_LEVEL, 64'h80000000);
      end_writes();
      // initializing beat carries a valid sample that must be ignored
      sample_queue = '{32'h7FFFFFFF, 32'sd1, 32'h7FFFFFFF, 32'sd0, 32'h80000000,
                       -32'sd1, 32'sd6553600};
      wait_idle();

      // reset default noise values at the smallest step
      write_reg(CSR_STEP_TIME, 1);
      write_reg(CSR_ALT_NOISE, 6554);
      write_reg(CSR_VEL_NOISE, 65536);
      write_reg(CSR_MEAS_NOISE, 131072);
      end_writes();
      sample_queue = '{32'sd1, 32'h7FFFFFFF, 32'sd0, 32'h80000000, 32'sd65536,
                       32'sd13107200, -32'sd65536};
      wait_idle();

      // wide registers saturate to the largest signed value
      write_reg(CSR_STEP_TIME, 65536);
      write_reg(CSR_ALT_NOISE, 64'hFFFFFFFF);
      write_reg(CSR_VEL_NOISE, 64'hFFFFFFFF);
      write_reg(CSR_MEAS_NOISE, 64'hFFFFFFFF);
      write_reg(CSR_INIT_ALT_VAR, 64'hFFFFFFFF);
      write_reg(CSR_INIT_VEL_VAR, 64'hFFFFFFFF);
      end_writes();
      sample_queue = '{32'sd1, 32'h7FFFFFFF, 32'h80000000, 32'sd0, 32'sd100000,
                       32'h55555555, 32'h2AAAAAAA};
      wait_idle();

      // random phases, each with fresh settings
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 5) begin
            write_reg(CSR_STEP_TIME, 655);
            write_reg(CSR_ALT_NOISE, 6554);
            write_reg(CSR_VEL_NOISE, 65536);
            write_reg(CSR_MEAS_NOISE, 131072);
            end_writes();
         end else begin
            random_settings(phase < 2);
         end
         for (int n = 0; n < 205; n++) sample_queue.push_back(random_sample());
         if (phase == 2) begin
            // long receiver hold-off while samples keep coming: input backs up
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (3000) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         wait_idle();
      end

      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_estimates.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // watchdog
   initial begin
      #10ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== altitude_velocity_kalman_filter.f =====
+incdir+sv
sv/avkf_pkg.sv
sv/altitude_velocity_kalman_filter.sv
bench/tb_top.sv
